[hw/rtl/fat_pkg.sv]
package fat_pkg;

	localparam int TableDepthDef = 64;

	localparam logic [1:0] OP_STORE   = 2'd0;
	localparam logic [1:0] OP_RESOLVE = 2'd1;
	localparam logic [1:0] OP_LENGTH  = 2'd2;
	localparam logic [1:0] OP_CLEAR   = 2'd3;

	localparam logic [1:0] ST_DONE = 2'd0;
	localparam logic [1:0] ST_BAD  = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	typedef struct packed {
		logic [11:0]        seq;
		logic [7:0]         frame;
		logic signed [12:0] tseq;
		logic signed [8:0]  tframe;
	} entry_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [11:0] out_seq;
		logic [7:0]  out_frame;
		logic        terminated;
		logic [7:0]  seq_length;
	} res_t;

endpackage

[hw/rtl/frame_alias_table.sv]
// Each beat scans the table entries, at most TABLE_DEPTH, and its result is
// registered (store and resolve stop at the first matching entry, clear and
// bad stores take no scan). A new beat waits until the last result is parked;
// the scan reads one entry per cycle via the table memory's single read port.
// Reset: arst_n empties the table (entry count 0) and drops any pending beat;
// memory contents are not cleared.
module frame_alias_table
	import fat_pkg::*;
#(
	parameter int TABLE_DEPTH = TableDepthDef,
	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// seq_number, frame_number, target_seq, target_frame, bitmap_frames, zero pad
	input  logic [55:0] s_tdata,
	// operation
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// status, out_seq, out_frame, terminated, seq_length, zero pad
	output logic [31:0] m_tdata
);

	entry_t        in_key;
	entry_t        rd_data;
	entry_t        wr_data;
	logic          rd_en;
	logic          wr_en;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] wr_addr;
	logic          res_valid;
	logic          res_take;
	res_t          res;

	logic          ovalid_q;
	res_t          ores_q;

	assign in_key.seq    = s_tdata[11:0];
	assign in_key.frame  = s_tdata[19:12];
	assign in_key.tseq   = s_tdata[32:20];
	assign in_key.tframe = s_tdata[41:33];

	fat_mem #(
		.DEPTH(TABLE_DEPTH)
	) u_mem (
		.clk    (clk),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data)
	);

	fat_scan #(
		.DEPTH(TABLE_DEPTH)
	) u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_op    (s_tuser),
		.in_key   (in_key),
		.in_bmp   (s_tdata[49:42]),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.res_valid(res_valid),
		.res_take (res_take),
		.res      (res)
	);

	// output register frees the scan as soon as a result is parked
	assign res_take = res_valid && (!ovalid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (res_take) begin
			ovalid_q <= 1'b1;
		end else if (m_tready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			ores_q <= res;
		end
	end

	assign m_tvalid = ovalid_q;
	assign m_tdata  = {1'b0, ores_q.seq_length, ores_q.terminated, ores_q.out_frame,
	                   ores_q.out_seq, ores_q.status};

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted while an item is in flight");

	a_res_parked: assert property (@(posedge clk) disable iff (!arst_n)
		res_take |=> m_tvalid)
		else $error("taken result not presented");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[1:0] == ST_DONE || m_tdata[1:0] == ST_BAD ||
		              m_tdata[1:0] == ST_FULL))
		else $error("illegal status code");

	a_no_write_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> res_take && !rd_en)
		else $error("table write outside result handoff");

endmodule

[hw/rtl/fat_mem.sv]
module fat_mem
	import fat_pkg::*;
#(
	parameter int DEPTH = TableDepthDef,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic          clk,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output entry_t        rd_data,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  entry_t        wr_data
);

	entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[hw/rtl/fat_scan.sv]
module fat_scan
	import fat_pkg::*;
#(
	parameter int DEPTH = TableDepthDef,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [1:0]    in_op,
	input  entry_t        in_key,
	input  logic [7:0]    in_bmp,
	output logic          rd_en,
	output logic [AW-1:0] rd_addr,
	input  entry_t        rd_data,
	output logic          wr_en,
	output logic [AW-1:0] wr_addr,
	output entry_t        wr_data,
	output logic          res_valid,
	input  logic          res_take,
	output res_t          res
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_RUN  = 2'd1;
	localparam logic [1:0] S_FIN  = 2'd2;

	logic [1:0]    state_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] ra_q;
	logic          rv_s1;
	logic [AW-1:0] ri_s1;

	logic [1:0]    op_q;
	entry_t        key_q;
	logic          found_q;
	logic          hterm_q;
	entry_t        hit_q;
	logic [AW-1:0] hidx_q;
	logic [7:0]    n_q;
	logic [7:0]    t_q;

	logic          bad;
	logic          skip;
	logic          match;
	logic          rterm;
	logic          hit_now;
	logic          issue;
	logic          done_run;
	logic          full;
	logic [7:0]    t_m1;

	assign bad      = (key_q.seq == 12'd0) || (key_q.frame == 8'd0);
	assign skip     = (op_q == OP_CLEAR) || ((op_q == OP_STORE) && bad);
	assign match    = (rd_data.seq == key_q.seq) && (rd_data.frame == key_q.frame);
	assign rterm    = rd_data.tseq[12] | rd_data.tframe[8];
	assign hit_now  = (state_q == S_RUN) && rv_s1 && match &&
	                  ((op_q == OP_STORE) || (op_q == OP_RESOLVE));
	assign issue    = (state_q == S_RUN) && !skip && !hit_now && (ra_q < cnt_q);
	assign done_run = skip || hit_now || (ra_q >= cnt_q);
	assign full     = (cnt_q >= CW'(DEPTH));
	assign t_m1     = t_q - 8'd1;

	assign in_ready = (state_q == S_IDLE);
	assign rd_en    = issue;
	assign rd_addr  = ra_q[AW-1:0];

	assign res_valid = (state_q == S_FIN);
	assign wr_en     = res_valid && res_take && (op_q == OP_STORE) && !bad &&
	                   (found_q || !full);
	assign wr_addr   = found_q ? hidx_q : cnt_q[AW-1:0];
	assign wr_data   = key_q;

	always_comb begin
		res = '0;
		case (op_q)
			OP_STORE: begin
				if (bad) begin
					res.status = ST_BAD;
				end else if (!found_q && full) begin
					res.status = ST_FULL;
				end else begin
					res.status = ST_DONE;
				end
			end
			OP_RESOLVE: begin
				if (found_q && !hterm_q) begin
					res.out_seq   = hit_q.tseq[11:0];
					res.out_frame = hit_q.tframe[7:0];
				end else begin
					res.out_seq   = key_q.seq;
					res.out_frame = key_q.frame;
				end
				res.terminated = found_q && hterm_q;
			end
			OP_LENGTH: begin
				if ((t_q != 8'd0) && ((n_q == 8'd0) || (t_m1 < n_q))) begin
					res.seq_length = t_m1;
				end else begin
					res.seq_length = n_q;
				end
			end
			default: begin
				res = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			ra_q    <= '0;
			rv_s1   <= 1'b0;
		end else begin
			rv_s1 <= issue;
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_RUN;
						ra_q    <= '0;
					end
				end
				S_RUN: begin
					if (issue) begin
						ra_q <= ra_q + CW'(1);
					end
					if (done_run) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (res_take) begin
						state_q <= S_IDLE;
						if (op_q == OP_CLEAR) begin
							cnt_q <= '0;
						end else if (wr_en && !found_q) begin
							cnt_q <= cnt_q + CW'(1);
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		ri_s1 <= ra_q[AW-1:0];
		if (in_valid && in_ready) begin
			op_q    <= in_op;
			key_q   <= in_key;
			n_q     <= in_bmp;
			t_q     <= 8'd0;
			found_q <= 1'b0;
		end else if ((state_q == S_RUN) && rv_s1) begin
			if (hit_now) begin
				found_q <= 1'b1;
				hterm_q <= rterm;
				hit_q   <= rd_data;
				hidx_q  <= ri_s1;
			end
			if ((op_q == OP_LENGTH) && (rd_data.seq == key_q.seq)) begin
				if (rterm) begin
					if ((t_q == 8'd0) || (rd_data.frame < t_q)) begin
						t_q <= rd_data.frame;
					end
				end else if (rd_data.frame > n_q) begin
					n_q <= rd_data.frame;
				end
			end
		end
	end

endmodule
